### src/wewa_pkg.sv
package wewa_pkg;

    localparam int WINDOW_MAX    = 64;
    localparam int FRACTION_BITS = 16;
    localparam int WEIGHT_BITS   = 23;

    localparam int SAMPLE_W = 32;
    localparam int WS_W     = 7;
    localparam int RATE_W   = 24;
    localparam int WGT_W    = WEIGHT_BITS + 1;
    localparam int POS_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int IDX_W    = ((POS_W > WS_W) ? POS_W : WS_W) + 1;
    localparam int WSUM_W   = WGT_W + $clog2(WINDOW_MAX) + 1;
    localparam int ACC_W    = 64;
    localparam int DIV_N    = 64;
    localparam int DIV_D    = (WSUM_W > RATE_W) ? WSUM_W : RATE_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE  = 2'd1;

    localparam logic [WGT_W-1:0]  WEIGHT_ONE = WGT_W'(1) << WEIGHT_BITS;
    localparam logic [RATE_W:0]   RATE_ONE   = (RATE_W + 1)'(1) << FRACTION_BITS;

endpackage

### src/wewa_if.sv
interface wewa_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [wewa_pkg::SAMPLE_W-1:0]  sample;
    logic                                  sample_valid;
    logic                                  series_start;
    modport source (output valid, sample, sample_valid, series_start, input ready);
    modport sink   (input valid, sample, sample_valid, series_start, output ready);
endinterface

interface wewa_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [wewa_pkg::SAMPLE_W-1:0]  average;
    logic                                  average_valid;
    modport source (output valid, average, average_valid, input ready);
    modport sink   (input valid, average, average_valid, output ready);
endinterface

interface wewa_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [wewa_pkg::CFG_IDX_W-1:0]        index;
    logic [wewa_pkg::RATE_W-1:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/wewa_window.sv
module wewa_window (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic                               i_wr_clear,
    input  logic [wewa_pkg::POS_W-1:0]         i_wr_addr,
    input  logic [wewa_pkg::SAMPLE_W-1:0]      i_wr_data,
    input  logic                               i_wr_flag,
    input  logic [wewa_pkg::POS_W-1:0]         i_rd_addr,
    output logic                               o_rd_flag,
    output logic [wewa_pkg::SAMPLE_W-1:0]      o_rd_data
);

    logic [wewa_pkg::SAMPLE_W-1:0] r_mem [wewa_pkg::WINDOW_MAX];
    logic [wewa_pkg::WINDOW_MAX-1:0] r_flags;
    logic [wewa_pkg::SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_wr_en) begin
            if (i_wr_clear) begin
                r_flags <= '0;
            end
            r_flags[i_wr_addr] <= i_wr_flag;
        end
    end

    assign o_rd_flag = r_flags[i_rd_addr];
    assign o_rd_data = r_rd_data;

endmodule

### src/wewa_div.sv
module wewa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wewa_pkg::DIV_N-1:0]     i_dividend,
    input  logic [wewa_pkg::DIV_D-1:0]     i_divisor,
    output logic                           o_done,
    output logic [wewa_pkg::DIV_N-1:0]     o_quotient
);

    localparam int N  = wewa_pkg::DIV_N;
    localparam int D  = wewa_pkg::DIV_D;
    localparam int CW = $clog2(N);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_q;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_den;
    logic [D:0]    trial;
    logic [D+1:0]  diff;
    logic          ge;

    assign trial = {r_rem, r_q[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign ge    = !diff[D+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N-2:0], ge};
            r_rem <= ge ? diff[D-1:0] : trial[D-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### src/windowed_exp_weighted_average.sv
// Windowed exponentially weighted average, one result per sample. Unless the
// window size or decay rate is zero, the walk reads one stored sample per
// cycle from the window memory (n = min(window_size, 64) samples), the drain
// state empties the multiply-accumulate pipeline and, for a nonzero weight
// sum, a radix-2 divider computes the final mean. A write of decay_rate above
// 1.0 computes the reciprocal on the same divider, during which no item or
// further configuration is taken. A finished result waits in the output
// register while the next sample is accepted.
module windowed_exp_weighted_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wewa_in_if.sink     i_in,
    wewa_cfg_if.sink    i_cfg,
    wewa_out_if.source  o_out
);

    localparam int POS_W  = wewa_pkg::POS_W;
    localparam int WS_W   = wewa_pkg::WS_W;
    localparam int IDX_W  = wewa_pkg::IDX_W;
    localparam int WGT_W  = wewa_pkg::WGT_W;
    localparam int RATE_W = wewa_pkg::RATE_W;
    localparam int ACC_W  = wewa_pkg::ACC_W;
    localparam int WSUM_W = wewa_pkg::WSUM_W;
    localparam int SW     = wewa_pkg::SAMPLE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RECIP = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIVWT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        r_state;
    logic [WS_W-1:0]   r_ws;
    logic [RATE_W-1:0] r_decay;
    logic [RATE_W-1:0] r_recip;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_item_pos;
    logic [WS_W-1:0]   r_n;
    logic [WS_W-1:0]   r_k;
    logic              r_fwd;
    logic [RATE_W-1:0] r_ratio;
    logic [WGT_W-1:0]  r_weight;
    logic              r_f1;
    logic [WGT_W-1:0]  r_w1;
    logic signed [ACC_W-1:0] r_prod;
    logic [WSUM_W-1:0] r_wadd;
    logic signed [ACC_W-1:0] r_xsum;
    logic [WSUM_W-1:0] r_wsum;
    logic              r_drain;
    logic signed [SW-1:0] r_res_avg;
    logic              r_res_v;
    logic              r_out_vld;
    logic signed [SW-1:0] r_out_avg;
    logic              r_out_avgv;

    logic in_acc, cfg_acc, out_acc, cfg_big, cfg_bad;
    logic [RATE_W:0]   decay_ext;
    logic [WS_W-1:0]   age;
    logic [IDX_W-1:0]  age_w, pos_w, idx_sum;
    logic [POS_W-1:0]  rd_addr;
    logic              rd_flag;
    logic [SW-1:0]     rd_data;
    logic [2*WGT_W-1:0] wmul;
    logic signed [SW+WGT_W:0] smul;
    logic [RATE_W+wewa_pkg::WEIGHT_BITS-1:0] bratio;
    logic              div_start, div_done;
    logic [wewa_pkg::DIV_N-1:0] div_dvd, div_q, mag;
    logic [wewa_pkg::DIV_D-1:0] div_dsr;
    logic [IDX_W-1:0]  ws_w;
    logic [SW-1:0]     qres;

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE) && !i_in.valid;

    assign decay_ext = {1'b0, i_cfg.data};
    assign cfg_big   = decay_ext > wewa_pkg::RATE_ONE;
    assign cfg_bad   = (r_ws == '0) || (r_decay == '0);
    assign ws_w      = IDX_W'(r_ws);
    assign bratio    = {r_decay, {wewa_pkg::WEIGHT_BITS{1'b0}}} >> wewa_pkg::FRACTION_BITS;

    assign age     = r_fwd ? (r_n - WS_W'(1) - r_k) : r_k;
    assign age_w   = IDX_W'(age);
    assign pos_w   = IDX_W'(r_item_pos);
    assign idx_sum = (age_w > pos_w) ? (pos_w + IDX_W'(wewa_pkg::WINDOW_MAX) - age_w)
                                     : (pos_w - age_w);
    assign rd_addr = idx_sum[POS_W-1:0];

    assign wmul = r_weight * WGT_W'(r_ratio);
    assign smul = $signed(rd_data) * $signed({1'b0, r_w1});

    assign mag = r_xsum[ACC_W-1] ? wewa_pkg::DIV_N'(-r_xsum) : wewa_pkg::DIV_N'(r_xsum);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = mag + wewa_pkg::DIV_N'(r_wsum >> 1);
        div_dsr   = wewa_pkg::DIV_D'(r_wsum);
        if (cfg_acc && i_cfg.index == wewa_pkg::REG_DECAY_RATE && cfg_big) begin
            div_start = 1'b1;
            div_dvd   = wewa_pkg::DIV_N'(1) << (wewa_pkg::WEIGHT_BITS + wewa_pkg::FRACTION_BITS);
            div_dsr   = wewa_pkg::DIV_D'(i_cfg.data);
        end else if (r_state == S_DIVGO && r_wsum != '0) begin
            div_start = 1'b1;
        end
    end

    assign qres = r_xsum[ACC_W-1] ? SW'(-div_q) : SW'(div_q);

    wewa_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (in_acc),
        .i_wr_clear (i_in.series_start),
        .i_wr_addr  (r_pos),
        .i_wr_data  (i_in.sample),
        .i_wr_flag  (i_in.sample_valid),
        .i_rd_addr  (rd_addr),
        .o_rd_flag  (rd_flag),
        .o_rd_data  (rd_data)
    );

    wewa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ws      <= '0;
            r_decay   <= '0;
            r_recip   <= '0;
            r_pos     <= '0;
            r_f1      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_f1 <= 1'b0;
            if (out_acc) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        if (i_cfg.index == wewa_pkg::REG_WINDOW_SIZE) begin
                            r_ws <= i_cfg.data[WS_W-1:0];
                        end else if (i_cfg.index == wewa_pkg::REG_DECAY_RATE) begin
                            r_decay <= i_cfg.data;
                            r_recip <= '0;
                            if (cfg_big) begin
                                r_state <= S_RECIP;
                            end
                        end
                    end else if (in_acc) begin
                        r_item_pos <= r_pos;
                        r_pos      <= (r_pos == POS_W'(wewa_pkg::WINDOW_MAX - 1))
                                      ? '0 : r_pos + POS_W'(1);
                        r_k        <= '0;
                        r_weight   <= wewa_pkg::WEIGHT_ONE;
                        r_n        <= (ws_w > IDX_W'(wewa_pkg::WINDOW_MAX))
                                      ? WS_W'(wewa_pkg::WINDOW_MAX) : r_ws;
                        r_fwd      <= ({1'b0, r_decay} > wewa_pkg::RATE_ONE);
                        r_ratio    <= ({1'b0, r_decay} > wewa_pkg::RATE_ONE)
                                      ? r_recip : bratio[RATE_W-1:0];
                        r_xsum     <= '0;
                        r_wsum     <= '0;
                        if (cfg_bad) begin
                            r_res_avg <= '0;
                            r_res_v   <= 1'b0;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_RECIP: begin
                    if (div_done) begin
                        r_recip <= div_q[RATE_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_WALK: begin
                    r_f1 <= rd_flag;
                    r_w1 <= r_weight;
                    if (rd_flag) begin
                        r_weight <= wmul[wewa_pkg::WEIGHT_BITS +: WGT_W];
                    end
                    r_k <= r_k + WS_W'(1);
                    if (r_k == r_n - WS_W'(1)) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    if (r_wsum == '0) begin
                        r_res_avg <= '0;
                        r_res_v   <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_DIVWT;
                    end
                end
                S_DIVWT: begin
                    if (div_done) begin
                        r_res_avg <= qres;
                        r_res_v   <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_avg  <= r_res_avg;
                        r_out_avgv <= r_res_v;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_WALK || r_state == S_DRAIN) begin
                r_xsum <= r_xsum + r_prod;
                r_wsum <= r_wsum + r_wadd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_f1 ? ACC_W'(smul) : '0;
        r_wadd <= r_f1 ? WSUM_W'(r_w1) : '0;
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.average       = r_out_avg;
    assign o_out.average_valid = r_out_avgv;

endmodule

### tb/windowed_exp_weighted_average_test.sv
`timescale 1ns / 100ps

module windowed_exp_weighted_average_test;

    localparam int SAMPLE_W      = wewa_pkg::SAMPLE_W;
    localparam int WINDOW_MAX    = wewa_pkg::WINDOW_MAX;
    localparam int POS_W         = wewa_pkg::POS_W;
    localparam int WS_W          = wewa_pkg::WS_W;
    localparam int RATE_W        = wewa_pkg::RATE_W;
    localparam int CFG_IDX_W     = wewa_pkg::CFG_IDX_W;
    localparam int FRACTION_BITS = wewa_pkg::FRACTION_BITS;
    localparam int WEIGHT_BITS   = wewa_pkg::WEIGHT_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       series_start;
    } t_sample_item;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic                       average_valid;
    } t_mean_result;

    logic i_clk;
    logic i_rst_n;

    wewa_in_if  in_ch();
    wewa_out_if out_ch();
    wewa_cfg_if cfg_ch();

    windowed_exp_weighted_average DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    t_sample_item pending_samples[$];
    t_mean_result expected_means[$];
    t_sample_item offered;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_req = 0;
    int cycles = 0;

    // shadow of the block
    logic signed [SAMPLE_W-1:0] hist_sample[WINDOW_MAX];
    logic                       hist_flag[WINDOW_MAX];
    logic [POS_W-1:0]           hist_pos;
    logic [WS_W-1:0]            sh_window;
    logic [RATE_W-1:0]          sh_rate;
    longint unsigned            sh_recip;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_mean_result predict_mean(t_sample_item it);
        t_mean_result    res;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] idx;
        int              n;
        int              age;
        bit              fwd;
        longint unsigned ratio;
        longint unsigned weight;
        longint unsigned wsum;
        longint unsigned mag;
        longint unsigned q;
        longint          xsum;
        bit              neg;
        pos = hist_pos;
        if (it.series_start) begin
            for (int i = 0; i < WINDOW_MAX; i++) hist_flag[i] = 1'b0;
        end
        hist_sample[pos] = it.sample;
        hist_flag[pos] = it.sample_valid;
        hist_pos = pos + 1'b1;
        res.average = '0;
        res.average_valid = 1'b0;
        if (sh_window == 0 || sh_rate == 0) return res;
        n = (sh_window > WINDOW_MAX) ? WINDOW_MAX : sh_window;
        fwd = sh_rate > (1 << FRACTION_BITS);
        ratio = fwd ? sh_recip : ((longint'(sh_rate) << WEIGHT_BITS) >> FRACTION_BITS);
        weight = 64'd1 << WEIGHT_BITS;
        wsum = 0;
        xsum = 0;
        for (int k = 0; k < n; k++) begin
            age = fwd ? (n - 1 - k) : k;
            idx = pos - POS_W'(age);
            if (hist_flag[idx]) begin
                wsum += weight;
                xsum += longint'(hist_sample[idx]) * longint'(weight);
                weight = (weight * ratio) >> WEIGHT_BITS;
            end
        end
        if (wsum != 0) begin
            neg = xsum < 0;
            mag = neg ? longint'(-xsum) : longint'(xsum);
            q = (mag + wsum / 2) / wsum;
            if (neg) q = -q;
            res.average = q[SAMPLE_W-1:0];
            res.average_valid = 1'b1;
        end
        return res;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.sample <= '0;
            in_ch.sample_valid <= 1'b0;
            in_ch.series_start <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) expected_means.push_back(predict_mean(offered));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_samples.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.sample <= offered.sample;
                    in_ch.sample_valid <= offered.sample_valid;
                    in_ch.series_start <= offered.series_start;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (hold_req) hold_left <= HOLD_CYCLES;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_mean_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_means.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction avg=%0d ok=%0b", $time,
                             out_ch.average, out_ch.average_valid);
                end else begin
                    exp_r = expected_means.pop_front();
                    if (exp_r.average !== out_ch.average) begin
                        errors++;
                        $display("%0t: average expected %0d actual %0d", $time,
                                 exp_r.average, out_ch.average);
                    end
                    if (exp_r.average_valid !== out_ch.average_valid) begin
                        errors++;
                        $display("%0t: average_valid expected %0b actual %0b", $time,
                                 exp_r.average_valid, out_ch.average_valid);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_ch.valid || expected_means.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [RATE_W-1:0] data);
        wait_drained();
        repeat (10) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (index == wewa_pkg::REG_WINDOW_SIZE) begin
            sh_window = data[WS_W-1:0];
        end else if (index == wewa_pkg::REG_DECAY_RATE) begin
            sh_rate = data;
            sh_recip = (data > (1 << FRACTION_BITS))
                       ? ((64'd1 << (WEIGHT_BITS + FRACTION_BITS)) / data) : 0;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_sample(logic signed [SAMPLE_W-1:0] s, logic sv, logic ss);
        t_sample_item it;
        it.sample = s;
        it.sample_valid = sv;
        it.series_start = ss;
        pending_samples.push_back(it);
    endtask

    task automatic add_random(int count);
        logic signed [SAMPLE_W-1:0] s;
        bit noise;
        for (int i = 0; i < count; i++) begin
            noise = $urandom_range(9) == 0;
            s = ($urandom_range(1) == 0) ? $urandom : ($urandom_range(8000000) - 4000000);
            if (noise)
                add_sample(s, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                add_sample(s, $urandom_range(9) != 0, $urandom_range(39) == 0);
        end
    endtask

    task automatic run_phase(logic [WS_W-1:0] ws, logic [RATE_W-1:0] rate, int count,
                             int send_pct, int recv_pct);
        write_reg(wewa_pkg::REG_WINDOW_SIZE, RATE_W'(ws));
        write_reg(wewa_pkg::REG_DECAY_RATE, rate);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        add_random(count);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            hist_sample[i] = '0;
            hist_flag[i] = 1'b0;
        end
        hist_pos = '0;
        sh_window = '0;
        sh_rate = '0;
        sh_recip = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // results out of reset, with window size and decay rate still zero
        add_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
        add_sample(32'sh0001_0000, 1'b1, 1'b0);
        wait_drained();
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'h000005);
        write_reg(wewa_pkg::REG_WINDOW_SIZE, 24'd4);
        add_sample(32'sh0003_0000, 1'b1, 1'b0);  // rate still zero
        wait_drained();
        write_reg(wewa_pkg::REG_DECAY_RATE, 24'h008000);
        add_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
        add_sample(32'sh7FFF_FFFF, 1'b1, 1'b0);
        add_sample(-32'sh8000_0000, 1'b1, 1'b0);
        add_sample(-32'sh8000_0000, 1'b1, 1'b0);
        add_sample(32'sh0000_0001, 1'b0, 1'b0);
        add_sample(32'sh1234_5678, 1'b0, 1'b1);  // empty window
        add_sample(-32'sh0000_0001, 1'b1, 1'b0);
        add_sample(32'sh0000_0002, 1'b1, 1'b0);
        add_sample(-32'sh0001_8000, 1'b1, 1'b1);
        wait_drained();
        write_reg(wewa_pkg::REG_DECAY_RATE, 24'h000001);  // weight underflow
        add_sample(32'sh0005_0000, 1'b1, 1'b0);
        add_sample(32'sh0007_0000, 1'b1, 1'b0);
        wait_drained();
        write_reg(wewa_pkg::REG_DECAY_RATE, 24'hFFFFFF);  // config change mid-series
        add_sample(-32'sh0002_0000, 1'b1, 1'b0);
        add_sample(32'sh0000_0000, 1'b1, 1'b0);
        wait_drained();
        write_reg(wewa_pkg::REG_WINDOW_SIZE, 24'd127);     // beyond storage
        add_sample(32'sh0009_0000, 1'b1, 1'b0);
        wait_drained();

        run_phase(7'd8, 24'h008000, 150, 0, 0);
        run_phase(7'd64, 24'h010000, 120, 84, 0);
        run_phase(7'd127, 24'hFFFFFF, 100, 0, 84);
        run_phase(7'd1, 24'h000001, 80, 22, 22);
        run_phase(7'd16, 24'h018000, 150, 0, 0);
        run_phase(7'd0, 24'h008000, 40, 22, 22);
        run_phase(7'd33, 24'h010001, 120, 84, 84);
        run_phase(7'd5, 24'd0, 40, 0, 22);

        // back-pressure: receiver holds off while the sender keeps offering
        write_reg(wewa_pkg::REG_WINDOW_SIZE, 24'd3);
        write_reg(wewa_pkg::REG_DECAY_RATE, 24'h00C000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge i_clk);
        hold_req = 1'b0;
        add_random(60);
        wait_drained();
        add_random(60);  // sender paused until drained, then resumes
        wait_drained();
        run_phase(7'd12, 24'h00F000, 150, 22, 22);

        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
